// ----- hw/rtl/wes_pkg.sv -----
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types, register indexes and fixed-point helpers of the wave stencil.
// ----------------------------------------------------------------------------
package wes_pkg;

  localparam int unsigned GridWidthDef  = 256;
  localparam int unsigned GridHeightDef = 256;
  localparam int unsigned SampleBits    = 32;
  localparam int unsigned WideBits      = 48;
  localparam int unsigned ProdBits      = 66;

  // configuration register indexes
  localparam logic [7:0] REG_SPEED_LEFT   = 8'd0;
  localparam logic [7:0] REG_SPEED_RIGHT  = 8'd1;
  localparam logic [7:0] REG_SPLIT_COLUMN = 8'd2;
  localparam logic [7:0] REG_COEF_X       = 8'd3;
  localparam logic [7:0] REG_COEF_Y       = 8'd4;
  localparam logic [7:0] REG_COEF_SRC     = 8'd5;
  localparam logic [7:0] REG_SOURCE_X     = 8'd6;
  localparam logic [7:0] REG_SOURCE_Y     = 8'd7;

  typedef struct packed {
    logic signed [31:0] current_sample;
    logic signed [31:0] older_sample;
    logic signed [31:0] source_value;
    logic               clear_max;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_sample;
    logic [7:0]         out_row;
    logic [7:0]         out_column;
    logic [31:0]        max_magnitude;
    logic               last_of_step;
  } out_item_t;

  typedef struct packed {
    logic [31:0] speed_left;
    logic [31:0] speed_right;
    logic [8:0]  split_column;
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [31:0] coef_src;
    logic [7:0]  source_x;
    logic [7:0]  source_y;
  } cfg_t;

  // one classified request with its five-point neighborhood
  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] uo;
    logic signed [31:0] e;
    logic signed [31:0] w;
    logic signed [31:0] n;
    logic signed [31:0] s;
    logic signed [31:0] src;
    logic [7:0]         out_row;
    logic [7:0]         out_column;
    logic               clear_max;
    logic               emit;
    logic               interior;
    logic               at_source;
    logic               right_c;
    logic               right_w;
    logic               last;
  } entry_t;

  function automatic logic signed [31:0] sat_sample(input logic signed [WideBits-1:0] x);
    logic signed [WideBits-1:0] hi;
    logic signed [WideBits-1:0] lo;
    hi = WideBits'(64'sd2147483647);
    lo = WideBits'(-64'sd2147483648);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // round half up back to Q8.24, then saturate
  function automatic logic signed [31:0] qround(input logic signed [ProdBits-1:0] p);
    logic signed [ProdBits-1:0] t;
    logic signed [ProdBits-25:0] s;
    t = p + ProdBits'(64'sd8388608);
    s = t[ProdBits-1:24];
    return sat_sample(WideBits'(s));
  endfunction

  function automatic logic [31:0] speed_x2(input logic [31:0] p);
    return p[31] ? 32'hffffffff : {p[30:0], 1'b0};
  endfunction

  function automatic logic [31:0] speed_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[32] ? 32'hffffffff : t[31:0];
  endfunction

endpackage

// ----- hw/rtl/wes_queue.sv -----
// ----------------------------------------------------------------------------
// wes_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module wes_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wes_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output wes_pkg::entry_t pop_data_o,
  output logic            empty_o
);
  import wes_pkg::*;

  entry_t     slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  // store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/wes_front.sv -----
// ----------------------------------------------------------------------------
// wes_front
// Accept cells, track raster position, read and update the row stores.
// ----------------------------------------------------------------------------
module wes_front #(
  parameter int unsigned GRID_WIDTH  = wes_pkg::GridWidthDef,
  parameter int unsigned GRID_HEIGHT = wes_pkg::GridHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wes_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wes_pkg::in_item_t in_data_i,
  output logic              push_o,
  output wes_pkg::entry_t   push_data_o,
  input  logic              full_i
);
  import wes_pkg::*;

  localparam int unsigned CW  = $clog2(GRID_WIDTH);
  localparam int unsigned RW  = $clog2(GRID_HEIGHT);
  localparam int unsigned CXW = (CW > 9) ? CW : 9;
  localparam int unsigned RXW = (RW > 8) ? RW : 8;

  localparam logic ST_ACC  = 1'b0;
  localparam logic ST_PUSH = 1'b1;

  logic signed [31:0] above_mem [GRID_WIDTH];
  logic signed [31:0] two_mem   [GRID_WIDTH];
  logic signed [31:0] older_mem [GRID_WIDTH];

  logic          state_q;
  logic [CW-1:0] col_q, addr_q;
  logic [RW-1:0] row_q;
  logic          accept;
  logic          last_c;
  logic [RW-1:0] er;
  logic [CW-1:0] col_e, col_w;
  entry_t        ent_q;
  in_item_t      item_q;

  assign in_ready_o = (state_q == ST_ACC);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (state_q == ST_PUSH) && !full_i;
  assign er         = row_q - RW'(1);
  assign col_e      = col_q + CW'(1);
  assign col_w      = col_q - CW'(1);
  assign last_c     = in_data_i.frame_end ||
                      (col_q == CW'(GRID_WIDTH - 1) && row_q == RW'(GRID_HEIGHT - 1));

  // store neighbors come from the registered reads; south and source from the held input
  always_comb begin
    push_data_o       = ent_q;
    push_data_o.s     = item_q.current_sample;
    push_data_o.src   = item_q.source_value;
  end

  // read the neighborhood on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_data_i;
      addr_q     <= col_q;
      ent_q.u    <= above_mem[col_q];
      ent_q.e    <= above_mem[col_e];
      ent_q.n    <= two_mem[col_q];
      ent_q.w    <= two_mem[col_w];
      ent_q.uo   <= older_mem[col_q];
      ent_q.s    <= in_data_i.current_sample;
      ent_q.src  <= in_data_i.source_value;
      ent_q.out_row    <= 8'(er);
      ent_q.out_column <= 8'(col_q);
      ent_q.clear_max  <= in_data_i.clear_max;
      ent_q.emit       <= (row_q != '0);
      ent_q.interior   <= (er != '0) && (row_q != '0) && (col_q != '0) &&
                          (col_q != CW'(GRID_WIDTH - 1));
      ent_q.at_source  <= (RXW'(er) == RXW'(cfg_i.source_y)) &&
                          (CXW'(col_q) == CXW'(cfg_i.source_x));
      ent_q.right_c    <= !(CXW'(col_q) < CXW'(cfg_i.split_column));
      ent_q.right_w    <= !(CXW'(col_w) < CXW'(cfg_i.split_column));
      ent_q.last       <= last_c;
    end
  end

  // shift the row stores once the request leaves
  always_ff @(posedge clk_i) begin
    if (push_o) begin
      two_mem[addr_q]   <= ent_q.u;
      above_mem[addr_q] <= item_q.current_sample;
      older_mem[addr_q] <= item_q.older_sample;
    end
  end

  // raster position and handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      if (accept) begin
        state_q <= ST_PUSH;
        if (last_c) begin
          col_q <= '0;
          row_q <= '0;
        end else if (col_q == CW'(GRID_WIDTH - 1)) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else if (push_o) begin
        state_q <= ST_ACC;
      end
    end
  end

endmodule

// ----- hw/rtl/wes_back.sv -----
// ----------------------------------------------------------------------------
// wes_back
// Evaluate the stencil with one shared multiplier and hold the result.
// ----------------------------------------------------------------------------
module wes_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wes_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  wes_pkg::entry_t    pop_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wes_pkg::out_item_t out_data_o
);
  import wes_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0]                 state_q;
  logic [3:0]                 cnt_q;
  entry_t                     work_q;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [31:0]         tx_q, ty_q, res_q, q, res;
  logic signed [WideBits-1:0] tot_q;
  logic [31:0]                max_q;
  logic signed [31:0]         a_op;
  logic [31:0]                b_op;
  logic [31:0]                pc, pw, sum_p;
  logic signed [32:0]         res_ext, mag;
  logic                       out_valid_q;
  out_item_t                  out_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop_o       = (state_q == B_IDLE) && !empty_i;

  assign pc      = work_q.right_c ? cfg_i.speed_right : cfg_i.speed_left;
  assign pw      = work_q.right_w ? cfg_i.speed_right : cfg_i.speed_left;
  assign sum_p   = speed_sum(pc, pw);
  assign q       = qround(prod_q);
  assign res     = sat_sample(tot_q);
  assign res_ext = 33'(res);
  assign mag     = res[31] ? -res_ext : res_ext;

  // pick the operands of the current product
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (cnt_q)
      4'd0: begin
        a_op = sat_sample(WideBits'(work_q.e) - WideBits'(work_q.u));
        b_op = speed_x2(pc);
      end
      4'd1: begin
        a_op = sat_sample(WideBits'(work_q.w) - WideBits'(work_q.u));
        b_op = speed_x2(pw);
      end
      4'd2: begin
        a_op = sat_sample(WideBits'(work_q.s) - WideBits'(work_q.u));
        b_op = sum_p;
      end
      4'd3: begin
        a_op = sat_sample(WideBits'(work_q.n) - WideBits'(work_q.u));
        b_op = sum_p;
      end
      4'd4: begin
        a_op = tx_q;
        b_op = cfg_i.coef_x;
      end
      4'd5: begin
        a_op = ty_q;
        b_op = cfg_i.coef_y;
      end
      4'd6: begin
        a_op = work_q.src;
        b_op = cfg_i.coef_src;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // datapath: multiply, then round and accumulate in the cycle after
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= pop_data_i;
      tot_q  <= (WideBits'(pop_data_i.u) <<< 1) - WideBits'(pop_data_i.uo);
      res_q  <= '0;
    end
    if (state_q == B_RUN) begin
      prod_q <= ProdBits'(a_op * $signed({1'b0, b_op}));
      unique case (cnt_q)
        4'd1: tx_q <= q;
        4'd2: tx_q <= sat_sample(WideBits'(tx_q) + WideBits'(q));
        4'd3: ty_q <= q;
        4'd4: ty_q <= sat_sample(WideBits'(ty_q) + WideBits'(q));
        4'd5, 4'd6: tot_q <= tot_q + WideBits'(q);
        4'd7: if (work_q.at_source) tot_q <= tot_q + WideBits'(q);
        4'd8: res_q <= res;
        default: begin
        end
      endcase
    end
    if (state_q == B_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.new_sample    <= res_q;
      out_q.out_row       <= work_q.out_row;
      out_q.out_column    <= work_q.out_column;
      out_q.max_magnitude <= max_q;
      out_q.last_of_step  <= work_q.last;
    end
  end

  // sequence one request at a time and track the running maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (pop_data_i.clear_max) max_q <= '0;
            cnt_q <= '0;
            if (pop_data_i.emit && pop_data_i.interior) begin
              state_q <= B_RUN;
            end else if (pop_data_i.emit) begin
              state_q <= B_OUT;
            end
          end
        end
        B_RUN: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd8) begin
            if (mag[31:0] > max_q) max_q <= mag[31:0];
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/wave_equation_stencil_step_top.sv -----
// ----------------------------------------------------------------------------
// wave_equation_stencil_step_top
// One time step of a 2D acoustic wave grid, five-point stencil, raster order.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid_i/in_ready_o   wes_pkg::in_item_t
// out      output     out_valid_o/out_ready_i wes_pkg::out_item_t
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The front takes a new cell only once the last is pushed (store read, then
// store update). An interior cell runs 7 products on one multiplier in the
// back between load, finish and output; boundary cells skip them and top-row
// cells give no output. A two-entry queue lets the front run ahead of the
// back. Reset clears counters and running maximum and loads the default
// configuration; row stores are not cleared. A stalled output holds the back.
module wave_equation_stencil_step_top #(
  parameter int unsigned GRID_WIDTH  = wes_pkg::GridWidthDef,
  parameter int unsigned GRID_HEIGHT = wes_pkg::GridHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wes_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wes_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import wes_pkg::*;

  cfg_t   cfg_q;
  logic   push, full, pop, empty;
  entry_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_left   <= 32'd167772;
      cfg_q.speed_right  <= 32'd671089;
      cfg_q.split_column <= 9'd128;
      cfg_q.coef_x       <= '0;
      cfg_q.coef_y       <= '0;
      cfg_q.coef_src     <= '0;
      cfg_q.source_x     <= '0;
      cfg_q.source_y     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SPEED_LEFT:   cfg_q.speed_left   <= cfg_data_i;
        REG_SPEED_RIGHT:  cfg_q.speed_right  <= cfg_data_i;
        REG_SPLIT_COLUMN: cfg_q.split_column <= cfg_data_i[8:0];
        REG_COEF_X:       cfg_q.coef_x       <= cfg_data_i;
        REG_COEF_Y:       cfg_q.coef_y       <= cfg_data_i;
        REG_COEF_SRC:     cfg_q.coef_src     <= cfg_data_i;
        REG_SOURCE_X:     cfg_q.source_x     <= cfg_data_i[7:0];
        REG_SOURCE_Y:     cfg_q.source_y     <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  wes_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  wes_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  wes_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("queue underflow");
  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_row == 8'd0 && GRID_HEIGHT <= 256)
      |-> out_data_o.new_sample == 32'sd0) else $error("boundary row not zero");
`endif

endmodule
